>>> hdl/crcwe_pkg.sv
// Shared constants, types and the fold column table for the word-wise CRC-32 engine.
// No dependencies; used by crcwe_fold and the top level.
`default_nettype none

package crcwe_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned S_TDATA_W  = 40;
    localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] SEED_RESET = 32'hFFFF_FFFF;

    // Byte count codes
    localparam logic [CNT_W-1:0] CNT_NONE  = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;

    typedef logic [CRC_W-1:0][CRC_W-1:0] t_fold_table;

    // Thirty-two MSB-first polynomial steps applied to a single set bit.
    // Only evaluated at elaboration to build the column table.
    function automatic logic [CRC_W-1:0] fold_unit(input int unsigned idx);
        logic [CRC_W-1:0] c;
        c = '0;
        c[idx] = 1'b1;
        for (int k = 0; k < CRC_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic t_fold_table build_fold_cols();
        t_fold_table t;
        for (int i = 0; i < CRC_W; i++) begin
            t[i] = fold_unit(i);
        end
        return t;
    endfunction

    // Column i is the 32-step image of bit i; the fold is linear over GF(2).
    localparam t_fold_table FOLD_COLS = build_fold_cols();

endpackage

`default_nettype wire

>>> hdl/crcwe_fold.sv
// Byte masking and one 32-bit CRC fold as a flat xor network.
// Depends on crcwe_pkg for the column table and count codes.
`default_nettype none

module crcwe_fold (
    input  wire logic [crcwe_pkg::CRC_W-1:0] i_crc_base,
    input  wire logic [crcwe_pkg::CRC_W-1:0] i_word,
    input  wire logic [crcwe_pkg::CNT_W-1:0] i_count,
    output logic      [crcwe_pkg::CRC_W-1:0] o_crc_next
);

    logic [crcwe_pkg::CRC_W-1:0] keep;
    logic [crcwe_pkg::CRC_W-1:0] c;
    logic [crcwe_pkg::CRC_W-1:0] folded;

    always_comb begin
        case (i_count)
            crcwe_pkg::CNT_ONE:   keep = 32'hFF00_0000;
            crcwe_pkg::CNT_TWO:   keep = 32'hFFFF_0000;
            crcwe_pkg::CNT_THREE: keep = 32'hFFFF_FF00;
            default:              keep = 32'hFFFF_FFFF;
        endcase
    end

    assign c = i_crc_base ^ (i_word & keep);

    always_comb begin
        folded = '0;
        for (int i = 0; i < crcwe_pkg::CRC_W; i++) begin
            if (c[i]) begin
                folded = folded ^ crcwe_pkg::FOLD_COLS[i];
            end
        end
    end

    // Zero count folds nothing: the base passes through.
    assign o_crc_next = (i_count == crcwe_pkg::CNT_NONE) ? i_crc_base : folded;

endmodule

`default_nettype wire

>>> hdl/crc32_msb_first_word_engine_unit.sv
// Word-wise CRC-32 (poly 0x04C11DB7, MSB first, no reflection, no final xor).
// Top level: input register, running CRC and result register around crcwe_fold.
// Depends on crcwe_pkg and crcwe_fold.
//
// Usage:
//   Input stream s_axis: tdata carries the data word (earliest byte in bits
//   31..24) and the valid byte count; tuser carries the first flag, which
//   restarts the CRC from the seed register before folding the word.
//   Output stream m_axis: one CRC value per accepted word, in order.
//   Seed port cfg: single 32-bit register, to be written by the user only
//   while the block is idle; the block itself does not enforce this.
// Throughput: one word per clock while not stalled; the running CRC is updated
//   by a single combinational fold between the input and result registers.
// Reset: seed and running CRC go to all ones, both stages empty.
// Stall: when m_axis_tready is low the result register holds; one more word
//   waits in the input register, then s_axis_tready drops until the result
//   is taken.
`default_nettype none

module crc32_msb_first_word_engine_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Seed register write
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [crcwe_pkg::CRC_W-1:0]       i_cfg_data,
    // Input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  wire logic [crcwe_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] first
    input  wire logic                              s_axis_tuser,
    // Output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] crc_value
    output logic      [crcwe_pkg::CRC_W-1:0]       m_axis_tdata
);

    logic [crcwe_pkg::CRC_W-1:0]   r_seed;
    logic [crcwe_pkg::CRC_W-1:0]   r_running;

    logic                          r_in_valid;
    logic [crcwe_pkg::CRC_W-1:0]   r_in_word;
    logic [crcwe_pkg::CNT_W-1:0]   r_in_count;
    logic                          r_in_first;

    logic                          r_out_valid;
    logic [crcwe_pkg::CRC_W-1:0]   r_out_crc;

    logic                          advance;
    logic                          s_take;
    logic [crcwe_pkg::CRC_W-1:0]   crc_base;
    logic [crcwe_pkg::CRC_W-1:0]   n_crc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= crcwe_pkg::SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_word  <= s_axis_tdata[31:0];
            r_in_count <= s_axis_tdata[34:32];
            r_in_first <= s_axis_tuser;
        end
    end

    assign crc_base = r_in_first ? r_seed : r_running;

    crcwe_fold u_fold (
        .i_crc_base (crc_base),
        .i_word     (r_in_word),
        .i_count    (r_in_count),
        .o_crc_next (n_crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= crcwe_pkg::SEED_RESET;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_running   <= n_crc;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_crc <= n_crc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_crc;

endmodule

`default_nettype wire

>>> tb/crc32_msb_first_word_engine_unit_tb.sv
// Self-checking bench for the word-wise MSB-first CRC-32 engine.
// Depends on crcwe_pkg and crc32_msb_first_word_engine_unit; drives the seed,
// input and result streams and compares every CRC against its own fold model.
`default_nettype none

module crc32_msb_first_word_engine_unit_tb;

    localparam int unsigned      CRC_W     = crcwe_pkg::CRC_W;
    localparam int unsigned      CNT_W     = crcwe_pkg::CNT_W;
    localparam int unsigned      S_TDATA_W = crcwe_pkg::S_TDATA_W;
    localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;
    localparam int               DRAIN_CYC = 8;
    localparam int               N_RANDOM  = 178;

    typedef struct packed {
        logic [CRC_W-1:0] word;
        logic [CNT_W-1:0] count;
        logic             first;
        logic             pause;   // hold off until all results are back
    } t_word_req;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CRC_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tready = 1'b0;
    logic                 o_cfg_ready;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [CRC_W-1:0]     m_axis_tdata;

    t_word_req        word_q[$];
    logic [CRC_W-1:0] crc_due_q[$];
    logic [CRC_W-1:0] seed_shadow = crcwe_pkg::SEED_RESET;
    logic [CRC_W-1:0] crc_shadow  = crcwe_pkg::SEED_RESET;
    int               src_idle_pct = 0;
    int               snk_idle_pct = 0;
    int               err_cnt      = 0;
    int               n_words      = 0;
    int               n_firsts     = 0;
    int               n_odd_cnt    = 0;
    int               n_seeds      = 0;
    t_word_req        nxt_req;
    logic [CRC_W-1:0] acc_word;
    logic [CNT_W-1:0] acc_count;

    crc32_msb_first_word_engine_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] data_word, [34:32] byte_count, [39:35] zero
        .s_axis_tuser  (s_axis_tuser),   // [0] first
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [31:0] crc_value
    );

    // Bitwise MSB-first fold of the masked word; counts above four keep all bytes.
    function automatic logic [CRC_W-1:0] fold_bytes(input logic [CRC_W-1:0] start,
                                                    input logic [CRC_W-1:0] word,
                                                    input logic [CNT_W-1:0] count);
        logic [CRC_W-1:0] keep;
        logic [CRC_W-1:0] c;
        case (count)
            crcwe_pkg::CNT_NONE:  keep = '0;
            crcwe_pkg::CNT_ONE:   keep = 32'hFF00_0000;
            crcwe_pkg::CNT_TWO:   keep = 32'hFFFF_0000;
            crcwe_pkg::CNT_THREE: keep = 32'hFFFF_FF00;
            default:              keep = '1;
        endcase
        if (count == crcwe_pkg::CNT_NONE) begin
            return start;
        end
        c = start ^ (word & keep);
        for (int k = 0; k < CRC_W; k++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ crcwe_pkg::CRC_POLY)
                           : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    function automatic t_word_req mk_req(input logic [CRC_W-1:0] word,
                                         input logic [CNT_W-1:0] count,
                                         input logic first);
        t_word_req r;
        r.word  = word;
        r.count = count;
        r.first = first;
        r.pause = 1'b0;
        return r;
    endfunction

    // Mostly full words in messages of random length; short tails and odd counts now and then.
    function automatic t_word_req rand_req();
        t_word_req r;
        int        sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            r.count = CNT_FOUR;
        end else if (sel < 88) begin
            r.count = CNT_W'($urandom_range(1, 3));
        end else if (sel < 94) begin
            r.count = crcwe_pkg::CNT_NONE;
        end else begin
            r.count = CNT_W'($urandom_range(5, 7));
        end
        sel = $urandom_range(0, 19);
        r.word  = (sel == 0) ? '0 : (sel == 1) ? '1 : CRC_W'($urandom);
        r.first = ($urandom_range(0, 5) == 0);
        r.pause = 1'b0;
        return r;
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Request driver plus predictor at the acceptance edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                acc_word  = s_axis_tdata[CRC_W-1:0];
                acc_count = s_axis_tdata[CRC_W+CNT_W-1:CRC_W];
                crc_shadow = fold_bytes(s_axis_tuser ? seed_shadow : crc_shadow,
                                        acc_word, acc_count);
                crc_due_q.push_back(crc_shadow);
                n_words++;
                if (s_axis_tuser) begin
                    n_firsts++;
                end
                if (acc_count == crcwe_pkg::CNT_NONE || acc_count > CNT_FOUR) begin
                    n_odd_cnt++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (word_q.size() != 0 && !(word_q[0].pause && crc_due_q.size() != 0)
                    && $urandom_range(0, 99) >= src_idle_pct) begin
                    nxt_req = word_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(S_TDATA_W-CRC_W-CNT_W){1'b0}}, nxt_req.count,
                                      nxt_req.word};
                    s_axis_tuser  <= nxt_req.first;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (crc_due_q.size() == 0) begin
                    $error("crc_value: unexpected result 0x%08h", m_axis_tdata);
                    err_cnt++;
                end else if (m_axis_tdata !== crc_due_q[0]) begin
                    $error("crc_value: expected 0x%08h, actual 0x%08h",
                           crc_due_q[0], m_axis_tdata);
                    err_cnt++;
                    void'(crc_due_q.pop_front());
                end else begin
                    void'(crc_due_q.pop_front());
                end
            end
        end
    end

    task automatic write_seed(input logic [CRC_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_shadow = value;
        i_cfg_valid <= 1'b0;
        n_seeds++;
    endtask

    task automatic wait_drained();
        while (word_q.size() != 0 || s_axis_tvalid || crc_due_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n, input int pause_at);
        t_word_req r;
        for (int i = 0; i < n; i++) begin
            r = rand_req();
            r.pause = (i == pause_at);
            word_q.push_back(r);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset seed, first=0 from the reset state, masks, odd counts
        src_idle_pct = 18;
        snk_idle_pct = 84;
        word_q.push_back(mk_req(32'h1234_5678, CNT_FOUR,             1'b0));
        word_q.push_back(mk_req(32'h0000_0000, CNT_FOUR,             1'b1));
        word_q.push_back(mk_req(32'hFFFF_FFFF, CNT_FOUR,             1'b0));
        word_q.push_back(mk_req(32'hFFFF_FFFF, crcwe_pkg::CNT_ONE,   1'b1));
        word_q.push_back(mk_req(32'hA5A5_A5A5, crcwe_pkg::CNT_TWO,   1'b0));
        word_q.push_back(mk_req(32'h5A5A_5A5A, crcwe_pkg::CNT_THREE, 1'b0));
        word_q.push_back(mk_req(32'hDEAD_BEEF, crcwe_pkg::CNT_NONE,  1'b0));
        word_q.push_back(mk_req(32'hFFFF_FFFF, crcwe_pkg::CNT_NONE,  1'b1));
        word_q.push_back(mk_req(32'h0102_0304, 3'd5,                 1'b0));
        word_q.push_back(mk_req(32'hCAFE_F00D, 3'd6,                 1'b1));
        word_q.push_back(mk_req(32'h8000_0001, 3'd7,                 1'b0));
        // "123456789" check string
        word_q.push_back(mk_req(32'h3132_3334, CNT_FOUR,             1'b1));
        word_q.push_back(mk_req(32'h3536_3738, CNT_FOUR,             1'b0));
        word_q.push_back(mk_req(32'h3900_0000, crcwe_pkg::CNT_ONE,   1'b0));
        word_q.push_back(mk_req(32'h8000_0000, CNT_FOUR,             1'b1));
        word_q.push_back(mk_req(32'h0000_0001, CNT_FOUR,             1'b0));
        word_q.push_back(mk_req(32'h0000_00FF, crcwe_pkg::CNT_THREE, 1'b0));
        wait_drained();

        write_seed(32'h0000_0000);
        queue_random(N_RANDOM, -1);
        wait_drained();

        src_idle_pct = 84;
        snk_idle_pct = 18;
        write_seed(32'hFFFF_FFFF);
        queue_random(N_RANDOM, N_RANDOM / 2);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_seed(CRC_W'($urandom));
        queue_random(N_RANDOM, -1);
        wait_drained();

        if (crc_due_q.size() != 0) begin
            $error("crc_value: %0d results never arrived", crc_due_q.size());
            err_cnt++;
        end
        $display("Checked %0d words (%0d restarts, %0d with zero or oversize count)",
                 n_words, n_firsts, n_odd_cnt);
        $display("Seed writes: %0d, across three stall patterns", n_seeds);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
